// ----- rtl/datetime_offset_to_epoch_core_defines.svh -----
// ----------------------------------------------------------------------------
// Datetime to epoch assertion macros
// Shared concurrent assertion templates used by the block checker.
// ----------------------------------------------------------------------------
`ifndef DATETIME_OFFSET_TO_EPOCH_CORE_DEFINES_SVH
`define DATETIME_OFFSET_TO_EPOCH_CORE_DEFINES_SVH

// Antecedent holds at an edge, consequent holds at the same edge
`define DTOE_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds at an edge, consequent holds at the next edge
`define DTOE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dtoe_pkg.sv -----
// ----------------------------------------------------------------------------
// Datetime to epoch package
// Field widths, time constants, month table and sequencer states.
// ----------------------------------------------------------------------------
package dtoe_pkg;

    // Field widths
    localparam int YEAR_W      = 12;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int HOUR_W      = 5;
    localparam int MINUTE_W    = 6;
    localparam int SECOND_W    = 6;
    localparam int OFF_HOUR_W  = 5;
    localparam int OFF_MIN_W   = 6;
    localparam int EPOCH_W     = 35;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 40;

    // Calendar and time constants
    localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
    localparam logic [6:0]  EPOCH_MOD100  = 7'd70;
    localparam logic [8:0]  EPOCH_MOD400  = 9'd370;
    localparam logic [6:0]  LAST_MOD100   = 7'd99;
    localparam logic [8:0]  LAST_MOD400   = 9'd399;
    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
    localparam logic [8:0]  DAYS_COMMON   = 9'd365;
    localparam logic [8:0]  DAYS_LEAP     = 9'd366;
    localparam logic [17:0] SECS_PER_DAY  = 18'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_YEARS,
        ST_MONTH,
        ST_SEC_DAYS,
        ST_SEC_HOUR,
        ST_SEC_MIN,
        ST_SEC_SEC,
        ST_SEC_OFF,
        ST_DONE
    } state_t;

    // Days in the year before the first of the given month (1..12)
    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] month);
        logic [8:0] d;
        unique case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/datetime_offset_to_epoch_core.sv -----
// ----------------------------------------------------------------------------
// Civil date and time to Unix epoch seconds
// Converts split date/time fields with a UTC offset to signed epoch seconds.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one date/time with its UTC offset per
//   transaction; output stream m_axis returns one epoch result per input.
//   s_axis_tready is high only while the sequencer is idle; one item is in
//   work at a time.
//   The year walk adds one year per cycle to the day count, and the month
//   step adds the rest of the days; the seconds terms then run through one
//   shared 35-bit accumulator, one term per cycle. A month or year out of
//   range goes from idle straight to the last state and returns zero
//   seconds with range_error set. The block takes no new item before it is
//   through with the last, since the sequencer passes through idle before
//   it takes the next item; that item can be taken while a result still
//   sits in the output register.
//   Reset clears the sequencer and the output valid; no result is pending.
//   When the receiver stalls, the result holds in the output register and
//   a finished second item waits in the last state until it is free.
// ----------------------------------------------------------------------------
module datetime_offset_to_epoch_core #(
    parameter int MAX_YEAR = 2399
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
    // [31:26] minute, [37:32] second, [38] offset_negative,
    // [43:39] offset_hours, [49:44] offset_minutes, [55:50] zero
    input  logic [dtoe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [34:0] epoch_seconds, [35] range_error, [39:36] zero
    output logic [dtoe_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import dtoe_pkg::*;

    // Day count width follows the largest year
    localparam int DAYS_W = $clog2((MAX_YEAR - 1969) * 366 + 400) + 1;
    localparam int PROD_W = DAYS_W + 18;

    // Input field decode
    logic [YEAR_W-1:0]     in_year;
    logic [MONTH_W-1:0]    in_month;
    logic                  in_bad;
    logic                  in_accept;

    assign in_year   = s_axis_tdata[11:0];
    assign in_month  = s_axis_tdata[15:12];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_bad    = (in_month < MONTH_FIRST) || (in_month > MONTH_LAST) ||
                       (in_year < EPOCH_YEAR) || (int'(in_year) > MAX_YEAR);

    // Registers
    state_t                   state_reg, state_next;
    logic [YEAR_W-1:0]        year_reg, year_next;
    logic [MONTH_W-1:0]       month_reg, month_next;
    logic [DAY_W-1:0]         day_reg, day_next;
    logic [HOUR_W-1:0]        hour_reg, hour_next;
    logic [MINUTE_W-1:0]      minute_reg, minute_next;
    logic [SECOND_W-1:0]      second_reg, second_next;
    logic                     neg_reg, neg_next;
    logic [OFF_HOUR_W-1:0]    offh_reg, offh_next;
    logic [OFF_MIN_W-1:0]     offm_reg, offm_next;
    logic [YEAR_W-1:0]        yr_reg, yr_next;
    logic [6:0]               m100_reg, m100_next;
    logic [8:0]               m400_reg, m400_next;
    logic signed [DAYS_W-1:0] days_reg, days_next;
    logic [EPOCH_W-1:0]       acc_reg, acc_next;
    logic                     err_reg, err_next;
    logic                     out_valid_reg, out_valid_next;
    logic [EPOCH_W-1:0]       out_epoch_reg, out_epoch_next;
    logic                     out_err_reg, out_err_next;

    // Year walk helpers
    logic                     leap;
    logic                     years_done;
    logic                     out_free;

    assign leap       = ((yr_reg[1:0] == 2'b00) && (m100_reg != 7'd0)) || (m400_reg == 9'd0);
    assign years_done = (yr_reg == year_reg);
    assign out_free   = !out_valid_reg || m_axis_tready;

    // Shared accumulator operand terms
    logic signed [PROD_W-1:0] days_prod;
    logic [16:0]              hour_secs;
    logic [16:0]              minute_secs;
    logic [16:0]              off_secs;
    logic [EPOCH_W-1:0]       operand;

    assign days_prod   = days_reg * $signed({1'b0, SECS_PER_DAY});
    assign hour_secs   = 17'(hour_reg) * SECS_PER_HOUR;
    assign minute_secs = 17'(minute_reg) * SECS_PER_MIN;
    assign off_secs    = 17'(offh_reg) * SECS_PER_HOUR + 17'(offm_reg) * SECS_PER_MIN;

    always_comb
    begin
        unique case (state_reg)
            ST_SEC_DAYS: operand = days_prod[EPOCH_W-1:0];
            ST_SEC_HOUR: operand = EPOCH_W'(hour_secs);
            ST_SEC_MIN:  operand = EPOCH_W'(minute_secs);
            ST_SEC_SEC:  operand = EPOCH_W'(second_reg);
            ST_SEC_OFF:  operand = neg_reg ? EPOCH_W'(off_secs) : (~EPOCH_W'(off_secs) + 1'b1);
            default:     operand = '0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = in_bad ? ST_DONE : ST_YEARS;
                end
            end
            ST_YEARS:
            begin
                if (years_done)
                begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:    state_next = ST_SEC_DAYS;
            ST_SEC_DAYS: state_next = ST_SEC_HOUR;
            ST_SEC_HOUR: state_next = ST_SEC_MIN;
            ST_SEC_MIN:  state_next = ST_SEC_SEC;
            ST_SEC_SEC:  state_next = ST_SEC_OFF;
            ST_SEC_OFF:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        second_next    = second_reg;
        neg_next       = neg_reg;
        offh_next      = offh_reg;
        offm_next      = offm_reg;
        yr_next        = yr_reg;
        m100_next      = m100_reg;
        m400_next      = m400_reg;
        days_next      = days_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        out_epoch_next = out_epoch_reg;
        out_err_next   = out_err_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        s_axis_tready  = (state_reg == ST_IDLE);

        unique case (state_reg)
            // Capture the item and seed the year walk
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    year_next   = in_year;
                    month_next  = in_month;
                    day_next    = s_axis_tdata[20:16];
                    hour_next   = s_axis_tdata[25:21];
                    minute_next = s_axis_tdata[31:26];
                    second_next = s_axis_tdata[37:32];
                    neg_next    = s_axis_tdata[38];
                    offh_next   = s_axis_tdata[43:39];
                    offm_next   = s_axis_tdata[49:44];
                    yr_next     = EPOCH_YEAR;
                    m100_next   = EPOCH_MOD100;
                    m400_next   = EPOCH_MOD400;
                    days_next   = '0;
                    acc_next    = '0;
                    err_next    = in_bad;
                end
            end
            // One whole year per cycle
            ST_YEARS:
            begin
                if (!years_done)
                begin
                    days_next = days_reg + $signed(DAYS_W'(leap ? DAYS_LEAP : DAYS_COMMON));
                    yr_next   = yr_reg + 1'b1;
                    m100_next = (m100_reg == LAST_MOD100) ? 7'd0 : (m100_reg + 1'b1);
                    m400_next = (m400_reg == LAST_MOD400) ? 9'd0 : (m400_reg + 1'b1);
                end
            end
            // Month table, leap day after February, day of month minus one
            ST_MONTH:
            begin
                days_next = days_reg
                          + $signed(DAYS_W'(days_before_month(month_reg)))
                          + $signed(DAYS_W'((month_reg > MONTH_FEB) && leap))
                          + $signed(DAYS_W'(day_reg))
                          - $signed(DAYS_W'(1));
            end
            ST_SEC_DAYS,
            ST_SEC_HOUR,
            ST_SEC_MIN,
            ST_SEC_SEC,
            ST_SEC_OFF:
            begin
                acc_next = acc_reg + operand;
            end
            // Hand the result to the output register
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_epoch_next = err_reg ? '0 : acc_reg;
                    out_err_next   = err_reg;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        year_reg      <= year_next;
        month_reg     <= month_next;
        day_reg       <= day_next;
        hour_reg      <= hour_next;
        minute_reg    <= minute_next;
        second_reg    <= second_next;
        neg_reg       <= neg_next;
        offh_reg      <= offh_next;
        offm_reg      <= offm_next;
        yr_reg        <= yr_next;
        m100_reg      <= m100_next;
        m400_reg      <= m400_next;
        days_reg      <= days_next;
        acc_reg       <= acc_next;
        err_reg       <= err_next;
        out_epoch_reg <= out_epoch_next;
        out_err_reg   <= out_err_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_err_reg, out_epoch_reg};

endmodule

// ----- rtl/dtoe_chk.sv -----
// ----------------------------------------------------------------------------
// Datetime to epoch port checker
// Watches the stream ports of the block and flags misbehavior over time.
// ----------------------------------------------------------------------------
`include "datetime_offset_to_epoch_core_defines.svh"

module dtoe_chk (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [dtoe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [dtoe_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import dtoe_pkg::*;

    logic in_xact;
    logic out_xact;

    assign in_xact  = s_axis_tvalid && s_axis_tready;
    assign out_xact = m_axis_tvalid && m_axis_tready;

    // A stalled result stays put
    `DTOE_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

    // One item in work at a time
    `DTOE_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_xact, !s_axis_tready, "input accepted while busy")

    // An error result carries zero seconds
    `DTOE_ASSERT_SAME(a_err_zero, clk, rst_n, m_axis_tvalid && m_axis_tdata[EPOCH_W], m_axis_tdata[EPOCH_W-1:0] == '0, "error result with nonzero seconds")

    // No result appears in the cycle right after an input transaction taken while no result was pending
    `DTOE_ASSERT_NEXT(a_no_instant_out, clk, rst_n, in_xact && !m_axis_tvalid, !m_axis_tvalid, "result too early")

    // Padding bits stay zero on a delivered result
    `DTOE_ASSERT_SAME(a_out_pad, clk, rst_n, out_xact, m_axis_tdata[OUT_TDATA_W-1:EPOCH_W+1] == '0, "nonzero padding")

endmodule

bind datetime_offset_to_epoch_core dtoe_chk u_dtoe_chk (.*);
